[rtl/block_reference_auditor_assert.svh]
// Assertion macros shared by the checker.
`ifndef BLOCK_REFERENCE_AUDITOR_ASSERT_SVH
`define BLOCK_REFERENCE_AUDITOR_ASSERT_SVH

// Same-cycle implication, clocked on clk and quiet while arst_n is low.
`define BRA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("block_reference_auditor: check failed");

// Next-cycle implication.
`define BRA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("block_reference_auditor: check failed");

`endif

[rtl/bra_pkg.sv]
package bra_pkg;

	// Widest relative block index and covered count the maps can reach (65536 bytes).
	localparam int unsigned REL_W = 19;
	localparam int unsigned COV_W = 20;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_NOTE  = 2'd2,
		OP_SCAN  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_RANGE   = 3'd1,
		ST_DUP     = 3'd2,
		ST_UNALLOC = 3'd3,
		ST_LEAK    = 3'd4
	} status_t;

	typedef enum logic {
		REG_DATA_BASE  = 1'b0,
		REG_DATA_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_NOTE,
		BK_SCAN
	} back_state_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		op_t              op;
		logic [11:0]      byte_index;
		logic [7:0]       byte_value;
		logic [REL_W-1:0] rel;
		logic             in_range;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] error_count;
		logic [2:0]  first_error;
		logic [14:0] leak_index;
	} rsp_t;

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Lowest set bit of a byte.
	function automatic logic [2:0] first_bit(logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

[rtl/bra_ram.sv]
module bra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/bra_queue.sv]
module bra_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/bra_front.sv]
module bra_front
	import bra_pkg::*;
#(
	parameter int unsigned MAP_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic [1:0]       op,
	input  logic [11:0]      byte_index,
	input  logic [7:0]       byte_value,
	input  logic [31:0]      block_lba,
	output cmd_t             cmd,
	output logic [COV_W-1:0] covered
);

	localparam int unsigned CAP = MAP_DEPTH * 8;

	logic [31:0] data_base_q;
	logic [15:0] data_count_q;
	logic [32:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q  <= '0;
			data_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DATA_BASE:  data_base_q  <= cfg_data;
				REG_DATA_COUNT: data_count_q <= cfg_data[15:0];
			endcase
		end
	end

	// Blocks past the end of the maps count as out of range.
	assign covered = (32'(data_count_q) < 32'(CAP)) ? COV_W'(data_count_q) : COV_W'(CAP);

	// Borrow out of the subtract means the address sits below the data area.
	assign diff = {1'b0, block_lba} - {1'b0, data_base_q};

	always_comb begin
		cmd.op         = op_t'(op);
		cmd.byte_index = byte_index;
		cmd.byte_value = byte_value;
		cmd.rel        = diff[REL_W-1:0];
		cmd.in_range   = !diff[32] && (diff[31:0] < 32'(covered));
	end

endmodule

[rtl/bra_back.sv]
module bra_back
	import bra_pkg::*;
#(
	parameter int unsigned MAP_DEPTH = 4096,
	localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [COV_W-1:0] covered,
	input  cmd_t             cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	input  logic             rsp_full,
	output logic             rsp_push,
	output rsp_t             rsp,
	output logic             init_busy
);

	back_state_t state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [2:0]    bit_q, bit_d;
	logic          sweep_rsp_q, sweep_rsp_d;
	logic [15:0]   err_q, err_d;
	logic [2:0]    first_q, first_d;

	logic          a_we, s_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    a_wdata, s_wdata, a_rd, s_rd;

	logic             start, in_map, sweep_last, scan_last;
	logic [COV_W-1:0] cov_m1;
	logic [AW-1:0]    last_idx, note_byte;
	logic [7:0]       tail_mask, scan_mask, cand;

	bra_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_alloc_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (a_wdata),
		.raddr (raddr),
		.rdata (a_rd)
	);

	bra_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_seen_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (waddr),
		.wdata (s_wdata),
		.raddr (raddr),
		.rdata (s_rd)
	);

	assign start      = !cmd_empty && !rsp_full;
	assign in_map     = 17'(cmd.byte_index) < 17'(MAP_DEPTH);
	assign note_byte  = AW'(cmd.rel[REL_W-1:3]);
	assign sweep_last = (idx_q == AW'(MAP_DEPTH - 1));
	assign cov_m1     = covered - COV_W'(1);
	assign last_idx   = AW'(cov_m1[COV_W-1:3]);
	assign scan_last  = (idx_q == last_idx);
	assign tail_mask  = (covered[2:0] == 3'd0) ? 8'hFF :
			8'((9'd1 << covered[2:0]) - 9'd1);
	assign scan_mask  = scan_last ? tail_mask : 8'hFF;
	assign cand       = a_rd & ~s_rd & scan_mask;
	assign init_busy  = (state_q == BK_SWEEP) && !sweep_rsp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_SWEEP: if (sweep_last) state_d = BK_IDLE;
			BK_IDLE: begin
				if (start) begin
					unique case (cmd.op)
						OP_CLEAR: state_d = BK_SWEEP;
						OP_LOAD:  state_d = BK_IDLE;
						OP_NOTE:  state_d = cmd.in_range ? BK_NOTE : BK_IDLE;
						OP_SCAN:  state_d = (covered == '0) ? BK_IDLE : BK_SCAN;
					endcase
				end
			end
			BK_NOTE: state_d = BK_IDLE;
			BK_SCAN: if (cand != 8'd0 || scan_last) state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		rsp_push    = 1'b0;
		a_we        = 1'b0;
		s_we        = 1'b0;
		waddr       = idx_q;
		a_wdata     = 8'd0;
		s_wdata     = 8'd0;
		raddr       = idx_q + AW'(1);
		idx_d       = idx_q;
		bit_d       = bit_q;
		sweep_rsp_d = sweep_rsp_q;
		err_d       = err_q;
		first_d     = first_q;
		rsp.status  = ST_OK;
		rsp.leak_index = 15'd0;

		unique case (state_q)
			BK_SWEEP: begin
				a_we  = 1'b1;
				s_we  = 1'b1;
				idx_d = idx_q + AW'(1);
				if (sweep_last) begin
					rsp_push = sweep_rsp_q;
				end
			end
			BK_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_CLEAR: begin
							err_d       = 16'd0;
							first_d     = 3'd0;
							idx_d       = '0;
							sweep_rsp_d = 1'b1;
						end
						OP_LOAD: begin
							a_we     = in_map;
							waddr    = AW'(cmd.byte_index);
							a_wdata  = cmd.byte_value;
							rsp_push = 1'b1;
						end
						OP_NOTE: begin
							if (cmd.in_range) begin
								raddr = note_byte;
								idx_d = note_byte;
								bit_d = cmd.rel[2:0];
							end else begin
								rsp.status = ST_RANGE;
								err_d      = sat_inc(err_q);
								first_d    = (first_q == 3'd0) ? ST_RANGE : first_q;
								rsp_push   = 1'b1;
							end
						end
						OP_SCAN: begin
							raddr = '0;
							idx_d = '0;
							rsp_push = (covered == '0);
						end
					endcase
				end
			end
			BK_NOTE: begin
				// Read-modify-write of the seen byte fetched in the previous cycle.
				rsp_push = 1'b1;
				if (s_rd[bit_q]) begin
					rsp.status = ST_DUP;
					err_d      = sat_inc(err_q);
					first_d    = (first_q == 3'd0) ? ST_DUP : first_q;
				end else begin
					s_we    = 1'b1;
					s_wdata = s_rd | (8'd1 << bit_q);
					if (!a_rd[bit_q]) begin
						rsp.status = ST_UNALLOC;
						err_d      = sat_inc(err_q);
						first_d    = (first_q == 3'd0) ? ST_UNALLOC : first_q;
					end
				end
			end
			BK_SCAN: begin
				// Byte idx_q is on the read port while idx_q + 1 is being fetched.
				idx_d = idx_q + AW'(1);
				if (cand != 8'd0) begin
					rsp.status     = ST_LEAK;
					rsp.leak_index = 15'({idx_q, first_bit(cand)});
					err_d          = sat_inc(err_q);
					first_d        = (first_q == 3'd0) ? ST_LEAK : first_q;
					rsp_push       = 1'b1;
				end else if (scan_last) begin
					rsp_push = 1'b1;
				end
			end
		endcase

		rsp.error_count = err_d;
		rsp.first_error = first_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_SWEEP;
			idx_q       <= '0;
			bit_q       <= '0;
			sweep_rsp_q <= 1'b0;
			err_q       <= '0;
			first_q     <= '0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			bit_q       <= bit_d;
			sweep_rsp_q <= sweep_rsp_d;
			err_q       <= err_d;
			first_q     <= first_d;
		end
	end

endmodule

[rtl/block_reference_auditor.sv]
// channel   handshake                 payload
// input     push / full               op, byte_index, byte_value, block_lba
// result    pop / empty               status, error_count, first_error, leak_index
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Load and out-of-range note are handled in the back end's idle state; in-range note also
// takes the note state for one seen-map read-modify-write through the map RAM ports. Scan: one map byte per cycle,
// stopping at the first leak or the last covered byte. Clear: one zero write per byte.
// After reset a clearing pass over every map byte runs with full held high.
// A two-entry request queue and a two-entry result queue let each side stall alone.
module block_reference_auditor
	import bra_pkg::*;
#(
	parameter int unsigned MAP_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [11:0] byte_index,
	input  logic [7:0]  byte_value,
	input  logic [31:0] block_lba,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [15:0] error_count,
	output logic [2:0]  first_error,
	output logic [14:0] leak_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t             cmd_in, cmd_out;
	rsp_t             rsp_in, rsp_out;
	logic [COV_W-1:0] covered;
	logic             cmd_full, cmd_empty, cmd_pop;
	logic             rsp_full, rsp_push;
	logic             init_busy;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full || init_busy;

	bra_front #(.MAP_DEPTH(MAP_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.byte_index (byte_index),
		.byte_value (byte_value),
		.block_lba  (block_lba),
		.cmd        (cmd_in),
		.covered    (covered)
	);

	bra_queue #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push && !full),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	bra_back #(.MAP_DEPTH(MAP_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.covered   (covered),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push),
		.rsp       (rsp_in),
		.init_busy (init_busy)
	);

	bra_queue #(.WIDTH($bits(rsp_t)), .DEPTH(2)) u_rsp_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rsp_push),
		.wdata  (rsp_in),
		.full   (rsp_full),
		.rd     (pop),
		.rdata  (rsp_out),
		.empty  (empty)
	);

	assign status      = rsp_out.status;
	assign error_count = rsp_out.error_count;
	assign first_error = rsp_out.first_error;
	assign leak_index  = rsp_out.leak_index;

endmodule

[rtl/bra_checker.sv]
`include "block_reference_auditor_assert.svh"

module bra_checker
	import bra_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic [15:0] error_count,
	input logic [2:0]  first_error,
	input logic [14:0] leak_index
);

	// Only a leak reports an index.
	`BRA_ASSERT_IMP(a_leak_index_only_on_leak, !empty && status != ST_LEAK, leak_index == 15'd0)

	// An error result has been counted and latched.
	`BRA_ASSERT_IMP(a_error_recorded, !empty && status != ST_OK, first_error != 3'd0 && error_count != 16'd0)

	// Count saturates rather than wrapping, so it is zero exactly when no error is latched.
	`BRA_ASSERT_IMP(a_count_matches_first, !empty, (first_error == 3'd0) == (error_count == 16'd0))

	// A waiting result holds until it is taken.
	`BRA_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(status) && $stable(error_count))

endmodule

bind block_reference_auditor bra_checker u_bra_checker (.*);
